>>> hw/rtl/uch_pkg.sv
// types and constants shared by the utf-8 code point histogram block
// no dependencies; imported by every module of the block

package uch_pkg;

	localparam int CODE_W    = 21;
	localparam int BYTE_W    = 8;
	localparam int RIDX_W    = 10;
	localparam int RCNT_W    = 32;
	localparam int CONT_BITS = 6;

	// lead byte boundaries
	localparam logic [BYTE_W-1:0] LEAD2_MIN    = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD3_MIN    = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD4_MIN    = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD_BAD_MIN = 8'hF8;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		OP_FEED = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic {
		KIND_CHAR = 1'b0,
		KIND_READ = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RDOUT
	} back_st_t;

	// one command from the decoder to the table engine
	typedef struct packed {
		op_t               op;
		logic [CODE_W-1:0] code;
		logic [RIDX_W-1:0] idx;
	} cmd_t;

endpackage

>>> hw/rtl/uch_front.sv
// front end: takes input transfers and rebuilds code points from utf-8 bytes
// depends on uch_pkg; feeds commands to uch_queue

module uch_front import uch_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  op_t               op,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic [RIDX_W-1:0] read_index,
	output logic              push,
	output cmd_t              cmd
);

	logic [1:0]        pending_q;
	logic [CODE_W-1:0] partial_q;
	logic [1:0]        nxt_pending;
	logic [CODE_W-1:0] nxt_partial;
	logic [CODE_W-1:0] cont_code;

	assign cont_code = {partial_q[CODE_W-CONT_BITS-1:0], data_byte[CONT_BITS-1:0]};

	always_comb begin
		nxt_pending = pending_q;
		nxt_partial = partial_q;
		push        = 1'b0;
		cmd.op      = OP_FEED;
		cmd.code    = '0;
		cmd.idx     = read_index;
		if (accept) begin
			if (op == OP_READ) begin
				// reads leave a partial sequence as it is
				push   = 1'b1;
				cmd.op = OP_READ;
			end else if (pending_q != 2'd0) begin
				nxt_pending = pending_q - 2'd1;
				if (pending_q == 2'd1) begin
					push        = 1'b1;
					cmd.code    = cont_code;
					nxt_partial = '0;
				end else begin
					nxt_partial = cont_code;
				end
			end else if (data_byte < LEAD2_MIN || data_byte >= LEAD_BAD_MIN) begin
				// ascii, stray continuation or invalid lead: taken raw
				push     = 1'b1;
				cmd.code = CODE_W'(data_byte);
			end else if (data_byte < LEAD3_MIN) begin
				nxt_partial = CODE_W'(data_byte[4:0]);
				nxt_pending = 2'd1;
			end else if (data_byte < LEAD4_MIN) begin
				nxt_partial = CODE_W'(data_byte[3:0]);
				nxt_pending = 2'd2;
			end else begin
				nxt_partial = CODE_W'(data_byte[2:0]);
				nxt_pending = 2'd3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
			partial_q <= '0;
		end else begin
			pending_q <= nxt_pending;
			partial_q <= nxt_partial;
		end
	end

endmodule

>>> hw/rtl/uch_queue.sv
// short command queue between the decoder and the table engine
// depends on uch_pkg for cmd_t and the queue depth

module uch_queue import uch_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	input  logic pop,
	output cmd_t pop_data,
	output logic empty,
	output logic full
);

	cmd_t               slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QFILL_W-1:0] fill_q;

	assign empty    = (fill_q == '0);
	assign full     = (fill_q == QFILL_W'(QUEUE_DEPTH));
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/uch_back.sv
// back end: searches the code point table, updates counts and answers reads
// depends on uch_pkg; holds the code and count memories and the result registers

module uch_back import uch_pkg::*; #(
	parameter int TABLE_DEPTH = 1024,
	parameter int COUNT_BITS  = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  cmd_t              pop_data,
	output logic              pop,
	output logic              done,
	output kind_t             kind,
	output logic [CODE_W-1:0] code,
	output logic [RCNT_W-1:0] count,
	output logic [RIDX_W-1:0] index,
	output logic              first,
	output logic              valid,
	output logic              full
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int USE_W = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W = (USE_W > RIDX_W) ? USE_W : RIDX_W;

	logic [CODE_W-1:0]     code_mem [TABLE_DEPTH];
	logic [COUNT_BITS-1:0] cnt_mem  [TABLE_DEPTH];

	back_st_t              st_q, st_nxt;
	cmd_t                  cur_q;
	logic [USE_W-1:0]      used_q;
	logic [USE_W-1:0]      scan_q;
	logic                  vld_s1;
	logic [IDX_W-1:0]      addr_s1;
	logic [CODE_W-1:0]     rd_code_s1;
	logic [COUNT_BITS-1:0] rd_cnt_s1;

	logic                  in_range;
	logic                  more;
	logic                  match;
	logic                  miss;
	logic                  room;
	logic                  rd_en;
	logic [IDX_W-1:0]      rd_addr;
	logic                  issue;
	logic                  cnt_we;
	logic                  code_we;
	logic [IDX_W-1:0]      wr_addr;
	logic [COUNT_BITS-1:0] wr_cnt;
	logic [COUNT_BITS-1:0] sat_cnt;
	logic                  used_inc;
	logic                  emit;
	kind_t                 e_kind;
	logic [CODE_W-1:0]     e_code;
	logic [COUNT_BITS-1:0] e_cnt;
	logic [RIDX_W-1:0]     e_idx;
	logic                  e_first;
	logic                  e_valid;
	logic                  e_full;

	logic                  done_q;
	kind_t                 kind_q;
	logic [CODE_W-1:0]     code_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [RIDX_W-1:0]     idx_q;
	logic                  first_q;
	logic                  valid_q;
	logic                  full_q;

	assign in_range = CMP_W'(pop_data.idx) < CMP_W'(used_q);
	assign more     = scan_q < used_q;
	assign match    = vld_s1 && (rd_code_s1 == cur_q.code);
	assign miss     = !more && !vld_s1;
	assign room     = used_q < USE_W'(TABLE_DEPTH);
	assign sat_cnt  = (&rd_cnt_s1) ? rd_cnt_s1 : rd_cnt_s1 + 1'b1;

	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (!empty) begin
					if (pop_data.op == OP_READ) begin
						st_nxt = in_range ? ST_RDOUT : ST_IDLE;
					end else begin
						st_nxt = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (match || miss) begin
					st_nxt = ST_IDLE;
				end
			end
			ST_RDOUT: st_nxt = ST_IDLE;
			default:  st_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = scan_q[IDX_W-1:0];
		issue    = 1'b0;
		cnt_we   = 1'b0;
		code_we  = 1'b0;
		wr_addr  = addr_s1;
		wr_cnt   = sat_cnt;
		used_inc = 1'b0;
		emit     = 1'b0;
		e_kind   = KIND_CHAR;
		e_code   = cur_q.code;
		e_cnt    = '0;
		e_idx    = '0;
		e_first  = 1'b0;
		e_valid  = 1'b0;
		e_full   = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				pop = !empty;
				if (!empty && pop_data.op == OP_READ) begin
					if (in_range) begin
						rd_en   = 1'b1;
						rd_addr = IDX_W'(pop_data.idx);
					end else begin
						emit   = 1'b1;
						e_kind = KIND_READ;
						e_code = '0;
						e_idx  = pop_data.idx;
					end
				end
			end
			ST_SCAN: begin
				// one entry read per cycle, compared in the cycle after its read
				issue = more && !match;
				rd_en = issue;
				if (match) begin
					cnt_we = 1'b1;
					emit   = 1'b1;
					e_cnt  = sat_cnt;
					e_idx  = RIDX_W'(addr_s1);
				end else if (miss) begin
					emit = 1'b1;
					if (room) begin
						cnt_we   = 1'b1;
						code_we  = 1'b1;
						wr_addr  = used_q[IDX_W-1:0];
						wr_cnt   = COUNT_BITS'(1);
						used_inc = 1'b1;
						e_cnt    = COUNT_BITS'(1);
						e_idx    = RIDX_W'(used_q);
						e_first  = 1'b1;
					end else begin
						e_full = 1'b1;
					end
				end
			end
			ST_RDOUT: begin
				emit    = 1'b1;
				e_kind  = KIND_READ;
				e_code  = rd_code_s1;
				e_cnt   = rd_cnt_s1;
				e_idx   = cur_q.idx;
				e_valid = 1'b1;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (code_we) begin
			code_mem[wr_addr] <= cur_q.code;
		end
		if (cnt_we) begin
			cnt_mem[wr_addr] <= wr_cnt;
		end
		if (rd_en) begin
			rd_code_s1 <= code_mem[rd_addr];
			rd_cnt_s1  <= cnt_mem[rd_addr];
			addr_s1    <= rd_addr;
		end
		if (pop) begin
			cur_q <= pop_data;
		end
		if (emit) begin
			kind_q  <= e_kind;
			code_q  <= e_code;
			cnt_q   <= e_cnt;
			idx_q   <= e_idx;
			first_q <= e_first;
			valid_q <= e_valid;
			full_q  <= e_full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			used_q <= '0;
			scan_q <= '0;
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_nxt;
			vld_s1 <= issue;
			done_q <= emit;
			if (pop) begin
				scan_q <= '0;
			end else if (issue) begin
				scan_q <= scan_q + 1'b1;
			end
			if (used_inc) begin
				used_q <= used_q + 1'b1;
			end
		end
	end

	assign done  = done_q;
	assign kind  = kind_q;
	assign code  = code_q;
	assign count = RCNT_W'(cnt_q);
	assign index = idx_q;
	assign first = first_q;
	assign valid = valid_q;
	assign full  = full_q;

endmodule

>>> hw/rtl/utf8_codepoint_histogram.sv
// Decodes a utf-8 byte stream and counts each distinct code point in a table of
// TABLE_DEPTH entries; reads return one entry. An item is taken when start is
// high and busy is low; busy rises only when the two-entry command queue is
// full. Results appear for one cycle with done and cannot be held off. A byte
// that completes a code point makes the table engine scan the used entries,
// reading one table entry per cycle through the single read port of the code
// and count memories until it finds a match or reaches the end; a read takes
// no scan, and bytes that open or continue a sequence never reach the engine.
// The table needs no clearing after reset.

module utf8_codepoint_histogram import uch_pkg::*; #(
	parameter int TABLE_DEPTH = 1024,
	parameter int COUNT_BITS  = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              operation,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic [RIDX_W-1:0] read_index,
	output logic              done,
	output logic              result_kind,
	output logic [CODE_W-1:0] code_point,
	output logic [RCNT_W-1:0] hit_count,
	output logic [RIDX_W-1:0] entry_index,
	output logic              first_seen,
	output logic              entry_valid,
	output logic              table_full
);

	logic  accept;
	logic  push;
	cmd_t  push_data;
	logic  pop;
	cmd_t  pop_data;
	logic  q_empty;
	logic  q_full;
	kind_t kind;

	assign busy   = q_full;
	assign accept = start && !q_full;

	uch_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.op         (op_t'(operation)),
		.data_byte  (data_byte),
		.read_index (read_index),
		.push       (push),
		.cmd        (push_data)
	);

	uch_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty),
		.full      (q_full)
	);

	uch_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.COUNT_BITS  (COUNT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.pop_data (pop_data),
		.pop      (pop),
		.done     (done),
		.kind     (kind),
		.code     (code_point),
		.count    (hit_count),
		.index    (entry_index),
		.first    (first_seen),
		.valid    (entry_valid),
		.full     (table_full)
	);

	assign result_kind = logic'(kind);

endmodule

>>> hw/rtl/uch_checker.sv
// port-level checks on the result flags of utf8_codepoint_histogram
// depends on uch_pkg; attached to the top level by the bind at the end

module uch_checker import uch_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              done,
	input logic              result_kind,
	input logic [CODE_W-1:0] code_point,
	input logic [RCNT_W-1:0] hit_count,
	input logic [RIDX_W-1:0] entry_index,
	input logic              first_seen,
	input logic              entry_valid,
	input logic              table_full
);

	// a readout never creates or drops an entry
	a_read_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done && result_kind == KIND_READ |-> !first_seen && !table_full)
		else $error("readout with first_seen or table_full");

	// a decoded character is never flagged as a valid readout
	a_char_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done && result_kind == KIND_CHAR |-> !entry_valid)
		else $error("decoded character with entry_valid");

	// a dropped code point carries no count and no position
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && table_full |-> hit_count == '0 && entry_index == '0 && !first_seen)
		else $error("dropped code point with count or index");

	// a new entry always starts at one
	a_first_one: assert property (@(posedge clk) disable iff (!arst_n)
		done && first_seen |-> hit_count == RCNT_W'(1))
		else $error("new entry with count other than one");

	// a read past the used entries returns a zero code point and count
	a_read_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && result_kind == KIND_READ && !entry_valid |->
			code_point == '0 && hit_count == '0)
		else $error("invalid readout with data");

endmodule

bind utf8_codepoint_histogram uch_checker u_chk (.*);
